// File: src/fec_pkg.sv
// ----------------------------------------------------------------------------
// fec_pkg
// Shared types, constants and helpers for the framing escape checksum encoder.
// ----------------------------------------------------------------------------
package fec_pkg;

    localparam logic [7:0] FLAG_VALUE      = 8'd126;
    localparam logic [7:0] ESCAPE_VALUE    = 8'd125;
    localparam logic [7:0] ESCAPE_CODE_ONE = 8'd1;
    localparam logic [7:0] ESCAPE_CODE_TWO = 8'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int NUM_SLOTS = 6;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam logic [SLOT_W-1:0] SLOT_START_FLAG = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_DATA       = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_DATA_CODE  = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_CSUM       = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_CSUM_CODE  = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_END_FLAG   = SLOT_W'(5);

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    typedef struct packed {
        slot_mask_t  mask;
        logic [7:0]  data;
        logic [7:0]  csum;
    } job_t;

    function automatic logic needs_escape(input logic [7:0] b);
        needs_escape = (b == ESCAPE_VALUE) || (b == FLAG_VALUE);
    endfunction

    // escape rule takes priority over flag rule
    function automatic logic [7:0] escape_code(input logic [7:0] b);
        escape_code = (b == ESCAPE_VALUE) ? ESCAPE_CODE_ONE : ESCAPE_CODE_TWO;
    endfunction

endpackage

// File: src/fec_front.sv
// ----------------------------------------------------------------------------
// fec_front
// Accepts message bytes, keeps the running XOR checksum and builds the job
// describing which framed bytes the back end must send.
// ----------------------------------------------------------------------------
module fec_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          first_byte,
    input  logic          last_byte,
    output fec_pkg::job_t job
);
    import fec_pkg::*;

    logic [7:0] csum_reg;
    logic [7:0] csum_next;
    logic [7:0] csum_new;
    slot_mask_t mask;

    always_comb
    begin
        csum_new  = (first_byte ? 8'd0 : csum_reg) ^ data_byte;
        csum_next = last_byte ? 8'd0 : csum_new;

        mask                  = '0;
        mask[SLOT_START_FLAG] = first_byte;
        mask[SLOT_DATA]       = 1'b1;
        mask[SLOT_DATA_CODE]  = needs_escape(data_byte);
        mask[SLOT_CSUM]       = last_byte;
        mask[SLOT_CSUM_CODE]  = last_byte & needs_escape(csum_new);
        mask[SLOT_END_FLAG]   = last_byte;

        job.mask = mask;
        job.data = data_byte;
        job.csum = csum_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_reg <= 8'd0;
        end
        else if (accept)
        begin
            csum_reg <= csum_next;
        end
    end

endmodule

// File: src/fec_queue.sv
// ----------------------------------------------------------------------------
// fec_queue
// Short job queue decoupling the front end from the byte sequencer.
// ----------------------------------------------------------------------------
module fec_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  fec_pkg::job_t wr_job,
    input  logic          rd_en,
    output fec_pkg::job_t rd_job,
    output logic          full,
    output logic          empty
);
    import fec_pkg::*;

    job_t                   store_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full   = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// File: src/fec_back.sv
// ----------------------------------------------------------------------------
// fec_back
// Byte sequencer: walks the slots of the head job into the output register,
// one framed byte per cycle while the output register is empty or being popped.
// ----------------------------------------------------------------------------
module fec_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  fec_pkg::job_t job,
    input  logic          job_empty,
    output logic          job_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_byte,
    output logic          frame_end,
    output logic          run_last
);
    import fec_pkg::*;

    logic              started_reg;
    logic              started_next;
    slot_mask_t        mask_reg;
    slot_mask_t        mask_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic              frame_end_reg;
    logic              frame_end_next;
    logic              run_last_reg;
    logic              run_last_next;

    slot_mask_t        cur_mask;
    slot_mask_t        rest_mask;
    logic [SLOT_W-1:0] sel;
    logic              emit;
    logic              done;

    always_comb
    begin
        cur_mask = started_reg ? mask_reg : job.mask;
        sel      = SLOT_DATA;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (cur_mask[i])
            begin
                sel = SLOT_W'(i);
            end
        end
        rest_mask      = cur_mask;
        rest_mask[sel] = 1'b0;

        emit = !job_empty && (!out_valid_reg || pop);
        done = emit && (rest_mask == '0);

        unique case (sel)
            SLOT_START_FLAG: out_byte_next = FLAG_VALUE;
            SLOT_DATA:
                out_byte_next = needs_escape(job.data) ? ESCAPE_VALUE : job.data;
            SLOT_DATA_CODE:  out_byte_next = escape_code(job.data);
            SLOT_CSUM:
                out_byte_next = needs_escape(job.csum) ? ESCAPE_VALUE : job.csum;
            SLOT_CSUM_CODE:  out_byte_next = escape_code(job.csum);
            SLOT_END_FLAG:   out_byte_next = FLAG_VALUE;
            default:         out_byte_next = FLAG_VALUE;
        endcase
        frame_end_next = (sel == SLOT_END_FLAG);
        run_last_next  = (rest_mask == '0);

        started_next   = started_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            started_next   = !done;
            mask_next      = rest_mask;
        end
    end

    assign job_pop   = done;
    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign run_last  = run_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg  <= out_byte_next;
            frame_end_reg <= frame_end_next;
            run_last_reg  <= run_last_next;
        end
    end

endmodule

// File: src/frame_escape_checksum_encoder.sv
// ----------------------------------------------------------------------------
// frame_escape_checksum_encoder
// The first framed byte passes through the job queue and then the output register.
// Throughput: one framed byte per cycle while the output is empty or popped;
// an input byte yields 1 to 6 framed bytes, as set by its job's slot mask.
// A two-entry job queue lets input transactions continue meanwhile.
// Reset (rst_n, async): clears checksum, queue pointers and output valid flag.
// ----------------------------------------------------------------------------
module frame_escape_checksum_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       frame_end,
    output logic       run_last
);
    import fec_pkg::*;

    job_t front_job;
    job_t head_job;
    logic accept;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    fec_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .job        (front_job)
    );

    fec_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_job (front_job),
        .rd_en  (q_pop),
        .rd_job (head_job),
        .full   (full),
        .empty  (q_empty)
    );

    fec_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_empty (q_empty),
        .job_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .run_last  (run_last)
    );

endmodule
